@@ sv/ufcb_pkg.sv @@
// Shared constants, payload types and control structs of the union-find balance core.
`default_nettype none

package ufcb_pkg;

    // Default vertex storage depth and the vertex count in use after reset.
    localparam int MAX_VERTICES_DEFAULT = 1024;
    localparam int NUM_VERTICES_RESET   = 1024;

    // Fixed field widths of the channels.
    localparam int VTX_W = 10;
    localparam int CNT_W = 11;

    // Compare width that holds any vertex count up to the largest storage depth.
    localparam int CMP_W = 17;

    // Edge counts saturate at this value.
    localparam logic [CNT_W-1:0] EDGE_SAT = 11'd2047;

    // One edge transfer.
    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic             last_edge;
    } t_edge;

    // One result transfer.
    typedef struct packed {
        logic [VTX_W-1:0] root;
        logic [CNT_W-1:0] component_vertices;
        logic [CNT_W-1:0] component_edges;
        logic             all_balanced;
        logic             verdict_final;
    } t_result;

    // Per-root counters as held in the count memory.
    typedef struct packed {
        logic [CNT_W-1:0] verts;
        logic [CNT_W-1:0] edges;
    } t_counts;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic find;
        logic comp;
        logic sel_b;
        logic cnt_a;
        logic cnt_b;
        logic apply;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        logic in_range;
        logic root_hit;
        logic comp_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/ufcb_if.sv @@
// Valid/ready channel interfaces for edges, results and the configuration write.
`default_nettype none

interface ufcb_edge_if;
    logic              valid;
    logic              ready;
    ufcb_pkg::t_edge   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ufcb_result_if;
    logic              valid;
    logic              ready;
    ufcb_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ufcb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ufcb_pkg::CNT_W-1:0]      num_vertices;

    modport source (output valid, output num_vertices, input ready);
    modport sink   (input valid, input num_vertices, output ready);
endinterface

`default_nettype wire

@@ sv/ufcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ufcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; a read of the address being written
    // returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/ufcb_ctrl.sv @@
// Sequencer of the union-find core: clearing pass, both root walks, count update, result.
`default_nettype none

module ufcb_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire ufcb_pkg::t_dp_status i_status,
    output      ufcb_pkg::t_dp_cmd    o_cmd,
    output      logic                 o_in_ready
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_FIND_A = 10'b00_0000_0100,
        S_COMP_A = 10'b00_0000_1000,
        S_FIND_B = 10'b00_0001_0000,
        S_COMP_B = 10'b00_0010_0000,
        S_CNT_A  = 10'b00_0100_0000,
        S_CNT_B  = 10'b00_1000_0000,
        S_APPLY  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and the command for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.in_range ? S_FIND_A : S_DONE;
                end
            end
            S_FIND_A: begin
                o_cmd.find = 1'b1;
                if (i_status.root_hit) begin
                    n_state = S_COMP_A;
                end
            end
            S_COMP_A: begin
                o_cmd.comp = 1'b1;
                if (i_status.comp_done) begin
                    n_state = S_FIND_B;
                end
            end
            S_FIND_B: begin
                o_cmd.find  = 1'b1;
                o_cmd.sel_b = 1'b1;
                if (i_status.root_hit) begin
                    n_state = S_COMP_B;
                end
            end
            S_COMP_B: begin
                o_cmd.comp  = 1'b1;
                o_cmd.sel_b = 1'b1;
                if (i_status.comp_done) begin
                    n_state = S_CNT_A;
                end
            end
            S_CNT_A: begin
                o_cmd.cnt_a = 1'b1;
                n_state     = S_CNT_B;
            end
            S_CNT_B: begin
                o_cmd.cnt_b = 1'b1;
                n_state     = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // A register write empties the graph, so the memories are swept again.
        if (i_status.cfg_wr) begin
            n_state = S_CLEAR;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ sv/ufcb_dp.sv @@
// Datapath of the union-find core: parent and count memories, walk registers, counters.
`default_nettype none

module ufcb_dp #(
    parameter int MAX_VERTICES = ufcb_pkg::MAX_VERTICES_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ufcb_pkg::t_dp_cmd          i_cmd,
    output      ufcb_pkg::t_dp_status       o_status,
    input  wire ufcb_pkg::t_edge            i_edge_data,
    input  wire logic                       i_cfg_wr,
    input  wire logic [ufcb_pkg::CNT_W-1:0] i_cfg_value,
    input  wire logic                       i_out_ready,
    output      logic                       o_out_valid,
    output      ufcb_pkg::t_result          o_out_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int XW  = ufcb_pkg::CMP_W;
    localparam int CW  = ufcb_pkg::CNT_W;
    localparam int TW  = $bits(ufcb_pkg::t_counts);
    localparam logic [XW-1:0] NUM_MAX = XW'(MAX_VERTICES);
    localparam logic [XW-1:0] NUM_RST =
        (ufcb_pkg::NUM_VERTICES_RESET > MAX_VERTICES) ? XW'(MAX_VERTICES)
                                                      : XW'(ufcb_pkg::NUM_VERTICES_RESET);
    localparam logic [VW-1:0] LAST_ADDR = VW'(MAX_VERTICES - 1);

    // Memory ports.
    logic          par_we;
    logic [VW-1:0] par_waddr;
    logic [VW-1:0] par_wdata;
    logic [VW-1:0] par_raddr;
    logic [VW-1:0] par_rdata;
    logic          cnt_we;
    logic [VW-1:0] cnt_waddr;
    logic [TW-1:0] cnt_wdata;
    logic [VW-1:0] cnt_raddr;
    logic [TW-1:0] cnt_rdata;

    // Edge and walk registers.
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic          r_last;
    logic          r_skip;
    logic [VW-1:0] r_cur;
    logic [VW-1:0] r_root;
    logic [VW-1:0] r_root_a;
    logic [VW-1:0] r_root_b;

    // Count registers.
    logic [CW-1:0] r_va;
    logic [CW-1:0] r_ea;
    logic          r_merged;
    logic [CW-1:0] r_vnew;
    logic [CW-1:0] r_enew;
    logic [CW-1:0] r_total;
    logic [CW-1:0] n_total;
    logic [XW-1:0] r_num;
    logic [XW-1:0] n_num;
    logic [VW-1:0] r_clr;

    // Combinational helpers.
    logic [XW-1:0]      a_ext;
    logic [XW-1:0]      b_ext;
    logic [XW-1:0]      cfg_ext;
    logic [XW-1:0]      root_ext;
    logic [VW-1:0]      start_addr;
    logic               root_hit;
    logic               comp_done;
    ufcb_pkg::t_counts  cnt_rd;
    ufcb_pkg::t_counts  cnt_clr;
    ufcb_pkg::t_counts  cnt_new;
    logic               bal_a;
    logic               bal_b;
    logic [CW-1:0]      vb_add;
    logic [CW-1:0]      eb_add;
    logic [CW-1:0]      vnew;
    logic [CW:0]        esum;
    logic [CW-1:0]      enew;
    logic [CW-1:0]      tot_part;
    ufcb_pkg::t_result  res;

    ufcb_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    ufcb_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Range check of the incoming edge and the clamped register value.
    assign a_ext   = XW'(i_edge_data.vertex_a);
    assign b_ext   = XW'(i_edge_data.vertex_b);
    assign cfg_ext = XW'(i_cfg_value);

    always_comb begin
        if (cfg_ext == '0) begin
            n_num = XW'(1);
        end else if (cfg_ext > NUM_MAX) begin
            n_num = NUM_MAX;
        end else begin
            n_num = cfg_ext;
        end
    end

    // Walk compares: the data read is always the parent of the current vertex.
    assign start_addr = i_cmd.sel_b ? r_b : r_a;
    assign root_hit   = (par_rdata == r_cur);
    assign comp_done  = (r_cur == r_root);

    assign o_status.cfg_wr    = i_cfg_wr;
    assign o_status.clr_last  = (r_clr == LAST_ADDR);
    assign o_status.in_range  = (a_ext < r_num) && (b_ext < r_num);
    assign o_status.root_hit  = root_hit;
    assign o_status.comp_done = comp_done;
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    // Parent memory read address: start of a walk, next hop, or restart for compression.
    always_comb begin
        par_raddr = r_cur;
        if (i_cmd.accept) begin
            par_raddr = a_ext[VW-1:0];
        end else if (i_cmd.find) begin
            par_raddr = root_hit ? start_addr : par_rdata;
        end else if (i_cmd.comp) begin
            par_raddr = comp_done ? r_b : par_rdata;
        end
    end

    // Parent memory writes: clearing, path compression, and hanging b's root under a's.
    always_comb begin
        par_we    = 1'b0;
        par_waddr = r_cur;
        par_wdata = r_root;
        if (i_cmd.clr_step) begin
            par_we    = 1'b1;
            par_waddr = r_clr;
            par_wdata = r_clr;
        end else if (i_cmd.comp && !comp_done) begin
            par_we = 1'b1;
        end else if (i_cmd.apply && r_merged) begin
            par_we    = 1'b1;
            par_waddr = r_root_b;
            par_wdata = r_root_a;
        end
    end

    // Count memory: root a is read while b's walk ends, root b in the next cycle.
    assign cnt_raddr     = i_cmd.cnt_a ? r_root_b : r_root_a;
    assign cnt_rd        = ufcb_pkg::t_counts'(cnt_rdata);
    assign cnt_clr.verts = CW'(1);
    assign cnt_clr.edges = '0;
    assign cnt_new.verts = r_vnew;
    assign cnt_new.edges = r_enew;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_root_a;
        cnt_wdata = TW'(cnt_new);
        if (i_cmd.clr_step) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr;
            cnt_wdata = TW'(cnt_clr);
        end else if (i_cmd.apply) begin
            cnt_we = 1'b1;
        end
    end

    // Merged counts and the balanced total with the old components taken out.
    always_comb begin
        bal_a    = (r_ea == r_va);
        bal_b    = r_merged && (cnt_rd.edges == cnt_rd.verts);
        vb_add   = r_merged ? cnt_rd.verts : '0;
        eb_add   = r_merged ? cnt_rd.edges : '0;
        vnew     = r_va + vb_add;
        esum     = {1'b0, r_ea} + {1'b0, eb_add} + (CW+1)'(1);
        enew     = (esum > {1'b0, ufcb_pkg::EDGE_SAT}) ? ufcb_pkg::EDGE_SAT : esum[CW-1:0];
        tot_part = r_total - (bal_a ? r_va : '0) - (bal_b ? cnt_rd.verts : '0);
    end

    // Balanced total update: clear, subtract old components, add the new one.
    always_comb begin
        n_total = r_total;
        if (i_cfg_wr) begin
            n_total = '0;
        end else if (i_cmd.cnt_b) begin
            n_total = tot_part;
        end else if (i_cmd.apply && (r_enew == r_vnew)) begin
            n_total = r_total + r_vnew;
        end
    end

    // Result assembly; an out-of-range edge reports a zero root and zero counts.
    assign root_ext = XW'(r_root_a);

    always_comb begin
        res.root               = r_skip ? '0 : root_ext[ufcb_pkg::VTX_W-1:0];
        res.component_vertices = r_skip ? '0 : r_vnew;
        res.component_edges    = r_skip ? '0 : r_enew;
        res.all_balanced       = (XW'(r_total) == r_num);
        res.verdict_final      = r_last;
    end

    // Control registers: register value, clear counter, total and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= NUM_RST;
            r_clr       <= '0;
            r_total     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            if (i_cfg_wr) begin
                r_num <= n_num;
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the edge, the walks and the counts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a    <= a_ext[VW-1:0];
            r_b    <= b_ext[VW-1:0];
            r_last <= i_edge_data.last_edge;
            r_skip <= !o_status.in_range;
            r_cur  <= a_ext[VW-1:0];
        end else if (i_cmd.find) begin
            if (root_hit) begin
                r_root <= r_cur;
                r_cur  <= start_addr;
            end else begin
                r_cur <= par_rdata;
            end
        end else if (i_cmd.comp) begin
            if (comp_done) begin
                if (i_cmd.sel_b) begin
                    r_root_b <= r_root;
                end else begin
                    r_root_a <= r_root;
                    r_cur    <= r_b;
                end
            end else begin
                r_cur <= par_rdata;
            end
        end
        if (i_cmd.cnt_a) begin
            r_va     <= cnt_rd.verts;
            r_ea     <= cnt_rd.edges;
            r_merged <= (r_root_a != r_root_b);
        end
        if (i_cmd.cnt_b) begin
            r_vnew <= vnew;
            r_enew <= enew;
        end
        if (i_cmd.load_out) begin
            o_out_data <= res;
        end
    end

endmodule

`default_nettype wire

@@ sv/union_find_component_balance_core.sv @@
// Top level of the union-find component balance core.
//
//  Channel    Direction  Payload                                     Transfer when
//  i_edge     in         vertex_a, vertex_b, last_edge               valid & ready
//  o_result   out        root, component_vertices, component_edges,  valid & ready
//                        all_balanced, verdict_final
//  i_cfg      in         num_vertices (also empties the graph)       valid & ready
//
// An edge walks from each endpoint to its root: every hop costs one read of the parent
// memory, once to find the root and once more to compress the path. An out-of-range
// edge skips both walks. After reset and after every num_vertices write, a clearing
// pass over all MAX_VERTICES addresses sweeps both memories; no edge is taken during it.
// The finished result waits in an output register, so a stalled result channel
// holds back only the following edge's completion, not its acceptance.
`default_nettype none

module union_find_component_balance_core #(
    parameter int MAX_VERTICES = ufcb_pkg::MAX_VERTICES_DEFAULT
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    ufcb_edge_if.sink       i_edge,
    ufcb_result_if.source   o_result,
    ufcb_cfg_if.sink        i_cfg
);

    ufcb_pkg::t_dp_cmd    cmd;
    ufcb_pkg::t_dp_status status;
    logic                 in_ready;
    logic                 cfg_wr;

    // The register port is always able to take a write.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign i_edge.ready = in_ready;

    ufcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ufcb_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_edge_data (i_edge.data),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_value (i_cfg.num_vertices),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_data  (o_result.data)
    );

endmodule

`default_nettype wire

@@ sv/ufcb_checker.sv @@
// Port-level assertions of the union-find core and their binding to the top level.
`default_nettype none

module ufcb_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire ufcb_pkg::t_result i_out_data,
    input wire logic              i_cfg_valid,
    input wire logic              i_cfg_ready
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Reset starts the clearing pass with no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("edge channel ready or result valid right after reset");

    // A register write restarts the clearing pass.
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready)
        else $error("edge taken right after a register write");

    // One edge at a time: no edge follows directly on an accepted one.
    a_one_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("edge accepted in back-to-back cycles");

    // A result with no vertices is the ignored-edge result, with zero root and edges.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.component_vertices == '0) |->
            (i_out_data.root == '0) && (i_out_data.component_edges == '0))
        else $error("empty component reported with a root or edges");

endmodule

bind union_find_component_balance_core ufcb_checker u_ufcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_edge.valid),
    .i_in_ready  (i_edge.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire

@@ sim/ufcb_balance_checker.sv @@
// Scoreboard for the union-find balance core: mirrors the disjoint sets and checks each result.
`timescale 1ns / 100ps

module ufcb_balance_checker #(
    parameter int MAX_VERTICES = ufcb_pkg::MAX_VERTICES_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_edge_valid,
    input  wire logic                       i_edge_ready,
    input  ufcb_pkg::t_edge                 i_edge_data,
    input  wire logic                       i_result_valid,
    input  wire logic                       i_result_ready,
    input  ufcb_pkg::t_result               i_result_data,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [ufcb_pkg::CNT_W-1:0] i_cfg_num_vertices,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_checked,
    output int                              o_ignored,
    output int                              o_balanced,
    output int                              o_saturated,
    output int                              o_graphs
);

    // Mirror of the disjoint-set forest and its per-root counters.
    int unsigned up_link [MAX_VERTICES];
    int unsigned vert_count [MAX_VERTICES];
    int unsigned edge_count [MAX_VERTICES];
    int unsigned balanced_total;
    int unsigned vertices_in_use;

    // Results owed by the block, oldest first.
    ufcb_pkg::t_result due_results [$];

    // Every vertex becomes its own singleton set.
    function automatic void empty_graph();
        for (int v = 0; v < MAX_VERTICES; v++) begin
            up_link[v]    = v;
            vert_count[v] = 1;
            edge_count[v] = 0;
        end
        balanced_total = 0;
    endfunction

    // A zero count means one vertex; counts beyond the storage depth are cut to it.
    function automatic int unsigned clamp_vertices(logic [ufcb_pkg::CNT_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_VERTICES) return MAX_VERTICES;
        return raw;
    endfunction

    // Walk to the root, then point every vertex on the path straight at it.
    function automatic int unsigned locate_root(int unsigned v);
        int unsigned r;
        int unsigned nxt;
        int unsigned hops;
        r    = v;
        hops = 0;
        while (up_link[r] != r && hops < MAX_VERTICES) begin
            r = up_link[r];
            hops++;
        end
        hops = 0;
        while (v != r && hops < MAX_VERTICES) begin
            nxt        = up_link[v];
            up_link[v] = r;
            v          = nxt;
            hops++;
        end
        return r;
    endfunction

    // Apply one edge to the mirror and return the result the block must report.
    function automatic ufcb_pkg::t_result merge_edge(ufcb_pkg::t_edge e);
        int unsigned       a;
        int unsigned       b;
        int unsigned       ra;
        int unsigned       rb;
        int unsigned       sum;
        ufcb_pkg::t_result res;
        a   = e.vertex_a;
        b   = e.vertex_b;
        res = '0;
        res.verdict_final = e.last_edge;
        // An endpoint outside the graph leaves everything untouched.
        if (a >= vertices_in_use || b >= vertices_in_use) begin
            res.all_balanced = (balanced_total == vertices_in_use);
            return res;
        end
        ra = locate_root(a);
        rb = locate_root(b);
        // Balanced sets leave the running total before they change.
        if (edge_count[ra] == vert_count[ra]) balanced_total -= vert_count[ra];
        if (rb != ra && edge_count[rb] == vert_count[rb]) balanced_total -= vert_count[rb];
        if (rb != ra) begin
            up_link[rb]     = ra;
            vert_count[ra] += vert_count[rb];
            sum             = edge_count[ra] + edge_count[rb] + 1;
        end else begin
            sum = edge_count[ra] + 1;
        end
        edge_count[ra] = (sum > ufcb_pkg::EDGE_SAT) ? ufcb_pkg::EDGE_SAT : sum;
        if (edge_count[ra] == vert_count[ra]) balanced_total += vert_count[ra];
        res.root               = ufcb_pkg::VTX_W'(ra);
        res.component_vertices = ufcb_pkg::CNT_W'(vert_count[ra]);
        res.component_edges    = ufcb_pkg::CNT_W'(edge_count[ra]);
        res.all_balanced       = (balanced_total == vertices_in_use);
        return res;
    endfunction

    // Check results first, then follow register writes and accepted edges.
    always @(posedge i_clk) begin
        ufcb_pkg::t_result got;
        ufcb_pkg::t_result want;
        if (!i_rst_n) begin
            vertices_in_use = clamp_vertices(ufcb_pkg::CNT_W'(ufcb_pkg::NUM_VERTICES_RESET));
            empty_graph();
            due_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_ignored    = 0;
            o_balanced   = 0;
            o_saturated  = 0;
            o_graphs     = 1;
        end else begin
            if (i_result_valid && i_result_ready) begin
                got = i_result_data;
                if (due_results.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("Result with no edge behind it: root %0d verts %0d edges %0d",
                                 got.root, got.component_vertices, got.component_edges);
                    o_mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (got.root !== want.root
                            || got.component_vertices !== want.component_vertices
                            || got.component_edges !== want.component_edges
                            || got.all_balanced !== want.all_balanced
                            || got.verdict_final !== want.verdict_final) begin
                        if (o_mismatches < 10) begin
                            $display("Result %0d wrong: expected root %0d verts %0d edges %0d %s",
                                     o_checked, want.root, want.component_vertices,
                                     want.component_edges,
                                     $sformatf("balanced %0b final %0b",
                                               want.all_balanced, want.verdict_final));
                            $display("    got root %0d verts %0d edges %0d balanced %0b final %0b",
                                     got.root, got.component_vertices, got.component_edges,
                                     got.all_balanced, got.verdict_final);
                        end
                        o_mismatches++;
                    end
                    o_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                vertices_in_use = clamp_vertices(i_cfg_num_vertices);
                empty_graph();
                o_graphs++;
            end
            if (i_edge_valid && i_edge_ready) begin
                want = merge_edge(i_edge_data);
                if (want.component_vertices == 0) o_ignored++;
                if (want.all_balanced) o_balanced++;
                if (want.component_edges == ufcb_pkg::EDGE_SAT) o_saturated++;
                due_results.push_back(want);
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

@@ sim/tb_union_find_component_balance_core.sv @@
// Testbench top: drives edges, vertex-count writes and result stalls into the balance core.
`timescale 1ns / 100ps

module tb_union_find_component_balance_core;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_GRAPHS = 14;
    localparam int CYCLE_SPAN    = 32;
    localparam int LOOP_EDGES    = 20;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   stall_left;
    int   cycles;
    int   mismatches;
    int   outstanding;
    int   checked;
    int   ignored;
    int   balanced;
    int   saturated;
    int   graphs;

    ufcb_edge_if   edge_ch ();
    ufcb_result_if result_ch ();
    ufcb_cfg_if    cfg_ch ();

    union_find_component_balance_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (edge_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    ufcb_balance_checker balance_chk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_edge_valid       (edge_ch.valid),
        .i_edge_ready       (edge_ch.ready),
        .i_edge_data        (edge_ch.data),
        .i_result_valid     (result_ch.valid),
        .i_result_ready     (result_ch.ready),
        .i_result_data      (result_ch.data),
        .i_cfg_valid        (cfg_ch.valid),
        .i_cfg_ready        (cfg_ch.ready),
        .i_cfg_num_vertices (cfg_ch.num_vertices),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding),
        .o_checked          (checked),
        .o_ignored          (ignored),
        .o_balanced         (balanced),
        .o_saturated        (saturated),
        .o_graphs           (graphs)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycles, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int idle_len(int none_pct);
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < none_pct) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Result side: ready drops for random stretches.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
            stall_left = idle_len(70);
        end
    end

    // Present one edge after an optional gap and hold it until its transfer.
    task automatic send_edge(int unsigned a, int unsigned b, bit last);
        int gap;
        gap = idle_len(55);
        @(negedge i_clk);
        if (gap > 0) begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= '{vertex_a: ufcb_pkg::VTX_W'(a), vertex_b: ufcb_pkg::VTX_W'(b),
                           last_edge: last};
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
    endtask

    // An edge that does not belong to the planned graph: in range or fully random.
    task automatic send_stray_edge(int unsigned n);
        if ($urandom_range(0, 99) < 65)
            send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                      $urandom_range(0, 15) == 0);
        else
            send_edge($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1));
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain();
        @(negedge i_clk);
        edge_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Vertex-count write on an idle block; it also empties the graph.
    task automatic write_vertex_count(logic [ufcb_pkg::CNT_W-1:0] value);
        drain();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.num_vertices <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Edges along the cycles of a random permutation of up to CYCLE_SPAN vertices balance them;
    // stray edges are mixed in, and more follow at the end.
    task automatic random_graph(logic [ufcb_pkg::CNT_W-1:0] setting, int n, int extra);
        int          m;
        int          i;
        int          j;
        int unsigned tmp;
        int unsigned cycle_map [CYCLE_SPAN];
        int unsigned order [CYCLE_SPAN];
        write_vertex_count(setting);
        m = (n < CYCLE_SPAN) ? n : CYCLE_SPAN;
        for (int k = 0; k < m; k++) begin
            cycle_map[k] = k;
            order[k]     = k;
        end
        for (int k = m - 1; k > 0; k--) begin
            j            = $urandom_range(0, k);
            tmp          = cycle_map[k];
            cycle_map[k] = cycle_map[j];
            cycle_map[j] = tmp;
            j            = $urandom_range(0, k);
            tmp          = order[k];
            order[k]     = order[j];
            order[j]     = tmp;
        end
        for (int k = 0; k < m; k++) begin
            if ($urandom_range(0, 99) < 12) send_stray_edge(n);
            i = order[k];
            if ($urandom_range(0, 1))
                send_edge(i, cycle_map[i], k == m - 1 || $urandom_range(0, 15) == 0);
            else
                send_edge(cycle_map[i], i, k == m - 1 || $urandom_range(0, 15) == 0);
        end
        repeat (extra) send_stray_edge(n);
    endtask

    // Stimulus: reset, directed graphs, random graphs, then a run of self loops.
    initial begin
        int pick;
        i_rst_n             = 1'b0;
        no_idle             = 1'b0;
        stall_left          = 0;
        cycles              = 0;
        edge_ch.valid       = 1'b0;
        edge_ch.data        = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.num_vertices = '0;
        result_ch.ready     = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default vertex count: self loops and merges at the field extremes.
        send_edge(0, 0, 1'b0);
        send_edge(1023, 1023, 1'b0);
        send_edge(0, 1023, 1'b0);
        send_edge(1023, 0, 1'b0);
        send_edge(512, 511, 1'b1);

        // A zero count means one vertex; any other endpoint is outside the graph.
        write_vertex_count(0);
        send_edge(1, 0, 1'b0);
        send_edge(0, 0, 1'b0);
        send_edge(1023, 0, 1'b1);
        send_edge(0, 1023, 1'b0);

        // All-ones count is cut to the full depth.
        write_vertex_count(11'h7FF);
        send_edge(1023, 512, 1'b0);
        send_edge(512, 1023, 1'b1);

        // A triangle is balanced; one more self loop breaks it.
        write_vertex_count(3);
        send_edge(0, 1, 1'b0);
        send_edge(1, 2, 1'b0);
        send_edge(2, 0, 1'b1);
        send_edge(3, 0, 1'b0);
        send_edge(0, 3, 1'b0);
        send_edge(2, 2, 1'b1);

        write_vertex_count(1025);
        send_edge(1023, 1023, 1'b1);

        // Random graphs over small, single, full and oversized vertex counts.
        for (int g = 0; g < RANDOM_GRAPHS; g++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(2, 24);
            if (g == 4) begin
                random_graph(1024, 1024, 12);
            end else if (g == 6) begin
                random_graph(1, 1, 12);
            end else if (g == 9) begin
                pick = $urandom_range(1025, 2047);
                random_graph(pick, 1024, 12);
            end else begin
                random_graph(pick, pick, 12);
            end
        end

        // One vertex collects a run of back-to-back self loops.
        no_idle = 1'b1;
        write_vertex_count(1);
        repeat (LOOP_EDGES) begin
            if ($urandom_range(0, 49) == 0) send_stray_edge(1);
            else send_edge(0, 0, $urandom_range(0, 31) == 0);
        end
        no_idle = 1'b0;

        drain();
        $display("Checked %0d results over %0d graphs: %0d ignored edges, %0d balanced verdicts.",
                 checked, graphs, ignored, balanced);
        $display("Edge count sat at its limit in %0d results.", saturated);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
